// ===== rtl/core/hclc_pkg.sv =====
// hclc_pkg: shared types and constants for the home climate and lamp controller
// op codes, register indexes, reset values and reciprocal constants for the conversions
// no dependencies
package hclc_pkg;

  typedef enum logic [2:0] {
    OP_SENSE = 3'd0,
    OP_LAMP  = 3'd1,
    OP_FAN   = 3'd2,
    OP_AUTO  = 3'd3,
    OP_TICK  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    REG_FAN_TEMP_ON     = 3'd0,
    REG_FAN_TEMP_OFF    = 3'd1,
    REG_FAN_HUM_ON      = 3'd2,
    REG_FAN_HUM_OFF     = 3'd3,
    REG_LIGHT_DARK      = 3'd4,
    REG_LIGHT_BRIGHT    = 3'd5,
    REG_TEMP_ALARM_HIGH = 3'd6,
    REG_DIST_ALARM_CM   = 3'd7
  } cfg_idx_t;

  localparam int CFG_DATA_W = 11;

  localparam logic [7:0]  RST_FAN_TEMP_ON     = 8'd30;
  localparam logic [7:0]  RST_FAN_TEMP_OFF    = 8'd27;
  localparam logic [7:0]  RST_FAN_HUM_ON      = 8'd80;
  localparam logic [7:0]  RST_FAN_HUM_OFF     = 8'd65;
  localparam logic [6:0]  RST_LIGHT_DARK      = 7'd30;
  localparam logic [6:0]  RST_LIGHT_BRIGHT    = 7'd70;
  localparam logic [7:0]  RST_TEMP_ALARM_HIGH = 8'd35;
  localparam logic [10:0] RST_DIST_ALARM_CM   = 11'd10;

  localparam logic [7:0] TEMP_ALARM_LOW = 8'd5;
  localparam logic [7:0] HUM_ALARM_HIGH = 8'd85;
  localparam logic [7:0] HUM_ALARM_LOW  = 8'd20;
  localparam logic [7:0] LIGHT_DELTA    = 8'd3;

  // light percent = (dark - adc) * 100 / (dark - bright), reduced by the common factor
  localparam logic [11:0] ADC_BRIGHT = 12'd250;
  localparam logic [11:0] ADC_DARK   = 12'd3600;
  localparam int LIGHT_GCD   = 50;
  localparam int PCT_NUM     = 100 / LIGHT_GCD;
  localparam int PCT_DEN     = (int'(ADC_DARK) - int'(ADC_BRIGHT)) / LIGHT_GCD;
  localparam int PCT_SHIFT   = 19;
  localparam int PCT_RECIP   = ((PCT_NUM << PCT_SHIFT) + PCT_DEN - 1) / PCT_DEN;
  localparam int PCT_RECIP_W = 14;
  localparam int PCT_PROD_W  = 12 + PCT_RECIP_W;

  // distance = echo / 58 by multiply and shift, exact over 16 bits
  localparam int ECHO_DIV     = 58;
  localparam int DIST_SHIFT   = 22;
  localparam int DIST_RECIP   = ((1 << DIST_SHIFT) + ECHO_DIV - 1) / ECHO_DIV;
  localparam int DIST_RECIP_W = 17;
  localparam int DIST_PROD_W  = 16 + DIST_RECIP_W;

  typedef struct packed {
    logic [6:0]  light_pct;
    logic [6:0]  after_pct;
    logic [10:0] dist_cm;
  } conv_t;

endpackage

// ===== rtl/core/hclc_if.sv =====
// hclc_if: valid/ready channel interfaces for the input item and the status result
// payload widths follow the controller's field list; no dependencies
interface hclc_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic        cmd_value;
  logic        climate_ok;
  logic [7:0]  temp_c;
  logic [7:0]  hum_pct;
  logic [11:0] light_adc;
  logic [11:0] light_after_adc;
  logic        echo_seen;
  logic [15:0] echo_count;

  modport source (
    output valid, op, cmd_value, climate_ok, temp_c, hum_pct, light_adc,
           light_after_adc, echo_seen, echo_count,
    input  ready
  );
  modport sink (
    input  valid, op, cmd_value, climate_ok, temp_c, hum_pct, light_adc,
           light_after_adc, echo_seen, echo_count,
    output ready
  );
endinterface

interface hclc_status_if;
  logic        valid;
  logic        ready;
  logic        lamp_on;
  logic        fan_on;
  logic        auto_mode;
  logic        lamp_fault;
  logic        alarm;
  logic [6:0]  light_pct;
  logic [10:0] range_cm;
  logic        distance_valid;
  logic [7:0]  temp_out;
  logic [7:0]  hum_out;
  logic [3:0]  motor_coils;

  modport source (
    output valid, lamp_on, fan_on, auto_mode, lamp_fault, alarm, light_pct,
           range_cm, distance_valid, temp_out, hum_out, motor_coils,
    input  ready
  );
  modport sink (
    input  valid, lamp_on, fan_on, auto_mode, lamp_fault, alarm, light_pct,
           range_cm, distance_valid, temp_out, hum_out, motor_coils,
    output ready
  );
endinterface

// ===== rtl/core/hclc_conv.sv =====
// hclc_conv: raw sensor conversions, light adc to percent and echo count to centimetres
// constant divisions done as reciprocal multiplies; uses hclc_pkg
module hclc_conv (
  input  logic [11:0]         light_adc,
  input  logic [11:0]         light_after_adc,
  input  logic [15:0]         echo_count,
  output hclc_pkg::conv_t     conv
);
  import hclc_pkg::*;

  logic [DIST_PROD_W-1:0] dist_prod;

  function automatic logic [6:0] adc_to_pct(input logic [11:0] raw);
    logic [11:0]           clamped;
    logic [11:0]           span;
    logic [PCT_PROD_W-1:0] prod;
    clamped = raw;
    if (raw < ADC_BRIGHT) begin
      clamped = ADC_BRIGHT;
    end else if (raw > ADC_DARK) begin
      clamped = ADC_DARK;
    end
    span = ADC_DARK - clamped;
    prod = PCT_PROD_W'(span) * PCT_PROD_W'(PCT_RECIP);
    return prod[PCT_SHIFT +: 7];
  endfunction

  assign dist_prod = DIST_PROD_W'(echo_count) * DIST_PROD_W'(DIST_RECIP);

  always_comb begin
    conv.light_pct = adc_to_pct(light_adc);
    conv.after_pct = adc_to_pct(light_after_adc);
    conv.dist_cm   = dist_prod[DIST_SHIFT +: 11];
  end

endmodule

// ===== rtl/core/home_climate_lamp_controller.sv =====
// home_climate_lamp_controller: top level, input register, state update and status output
// depends on hclc_pkg, hclc_if (hclc_item_if, hclc_status_if) and hclc_conv
//
//  channel  dir  kind          beat / write
//  item     in   valid/ready   op, command and sensor sample
//  status   out  valid/ready   lamp, fan, alarm and sensor state after the item
//  wr_*     in   write enable  config register index and data
//
// one item per cycle while status is not stalled; an item beat goes through the input
// register (conversion multiplies before it), then the state update to the status output
// rst is synchronous, clears valid flags and controller state, loads register defaults
// a stalled status beat holds the pipe; the input register still takes one more item
module home_climate_lamp_controller (
  input  logic                             clk,
  input  logic                             rst,
  hclc_item_if.sink                        item,
  hclc_status_if.source                    status,
  input  logic                             wr_en,
  input  hclc_pkg::cfg_idx_t               wr_index,
  input  logic [hclc_pkg::CFG_DATA_W-1:0]  wr_data
);
  import hclc_pkg::*;

  // config registers
  logic [7:0]  fan_t_start;
  logic [7:0]  fan_t_stop;
  logic [7:0]  fan_h_start;
  logic [7:0]  fan_h_stop;
  logic [6:0]  dim_pct;
  logic [6:0]  glare_pct;
  logic [7:0]  temp_alarm_high;
  logic [10:0] near_cm;

  // input register
  logic        s1_valid;
  op_t         s1_op;
  logic        s1_cmd;
  logic        s1_climate_ok;
  logic [7:0]  s1_temp;
  logic [7:0]  s1_hum;
  logic        s1_echo;
  conv_t       s1_conv;
  conv_t       conv;

  // controller state, also the status payload
  logic        out_valid;
  logic [7:0]  temp, temp_next;
  logic [7:0]  hum, hum_next;
  logic [6:0]  light, light_next;
  logic [10:0] range_cm, range_cm_next;
  logic        dist_ok, dist_ok_next;
  logic        lamp, lamp_next;
  logic        fan, fan_next;
  logic        auto_mode, auto_mode_next;
  logic        fault, fault_next;
  logic        alarm, alarm_next;
  logic [1:0]  phase, phase_next;

  logic        advance;
  logic        take;
  logic        step;

  logic [7:0]  new_temp;
  logic [7:0]  new_hum;
  logic [10:0] new_dist;
  logic        near;
  logic        go_dark;
  logic        go_bright;
  logic        dark_fault;
  logic        bright_fault;
  logic        fan_start;
  logic        fan_stop;

  hclc_conv u_conv (
    .light_adc       (item.light_adc),
    .light_after_adc (item.light_after_adc),
    .echo_count      (item.echo_count),
    .conv            (conv)
  );

  assign advance    = !out_valid || status.ready;
  assign item.ready = !s1_valid || advance;
  assign take       = item.valid && item.ready;
  assign step       = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      fan_t_start     <= RST_FAN_TEMP_ON;
      fan_t_stop      <= RST_FAN_TEMP_OFF;
      fan_h_start     <= RST_FAN_HUM_ON;
      fan_h_stop      <= RST_FAN_HUM_OFF;
      dim_pct         <= RST_LIGHT_DARK;
      glare_pct       <= RST_LIGHT_BRIGHT;
      temp_alarm_high <= RST_TEMP_ALARM_HIGH;
      near_cm         <= RST_DIST_ALARM_CM;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FAN_TEMP_ON:     fan_t_start     <= wr_data[7:0];
        REG_FAN_TEMP_OFF:    fan_t_stop      <= wr_data[7:0];
        REG_FAN_HUM_ON:      fan_h_start     <= wr_data[7:0];
        REG_FAN_HUM_OFF:     fan_h_stop      <= wr_data[7:0];
        REG_LIGHT_DARK:      dim_pct         <= wr_data[6:0];
        REG_LIGHT_BRIGHT:    glare_pct       <= wr_data[6:0];
        REG_TEMP_ALARM_HIGH: temp_alarm_high <= wr_data[7:0];
        REG_DIST_ALARM_CM:   near_cm         <= wr_data[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_op         <= op_t'(item.op);
      s1_cmd        <= item.cmd_value;
      s1_climate_ok <= item.climate_ok;
      s1_temp       <= item.temp_c;
      s1_hum        <= item.hum_pct;
      s1_echo       <= item.echo_seen;
      s1_conv       <= conv;
    end
  end

  // sense sample terms
  assign new_temp     = s1_climate_ok ? s1_temp : temp;
  assign new_hum      = s1_climate_ok ? s1_hum : hum;
  assign new_dist     = s1_echo ? s1_conv.dist_cm : 11'd0;
  assign near         = s1_echo && (new_dist < near_cm);
  assign go_dark      = (s1_conv.light_pct < dim_pct) && !lamp;
  assign go_bright    = (s1_conv.light_pct > glare_pct) && lamp;
  assign dark_fault   = {1'b0, s1_conv.after_pct} <= ({1'b0, s1_conv.light_pct} + LIGHT_DELTA);
  assign bright_fault = {1'b0, s1_conv.light_pct} <= ({1'b0, s1_conv.after_pct} + LIGHT_DELTA);
  assign fan_start    = ((new_temp > fan_t_start) || (new_hum > fan_h_start)) && !fan;
  assign fan_stop     = (new_temp < fan_t_stop) && (new_hum < fan_h_stop) && fan;

  always_comb begin
    temp_next      = temp;
    hum_next       = hum;
    light_next     = light;
    range_cm_next  = range_cm;
    dist_ok_next   = dist_ok;
    lamp_next      = lamp;
    fan_next       = fan;
    auto_mode_next = auto_mode;
    fault_next     = fault;
    alarm_next     = alarm;
    phase_next     = phase;
    unique case (s1_op)
      OP_SENSE: begin
        temp_next     = new_temp;
        hum_next      = new_hum;
        light_next    = s1_conv.light_pct;
        range_cm_next = new_dist;
        dist_ok_next  = s1_echo;
        if (auto_mode) begin
          if (go_dark) begin
            lamp_next  = 1'b1;
            fault_next = dark_fault;
          end else if (go_bright) begin
            lamp_next  = 1'b0;
            fault_next = bright_fault;
          end
          if (fan_start) begin
            fan_next = 1'b1;
          end else if (fan_stop) begin
            fan_next = 1'b0;
          end
        end
        alarm_next = (new_temp > temp_alarm_high) || (new_temp < TEMP_ALARM_LOW) ||
                     (new_hum > HUM_ALARM_HIGH) || (new_hum < HUM_ALARM_LOW) ||
                     fault_next || near;
      end
      OP_LAMP: lamp_next      = s1_cmd;
      OP_FAN:  fan_next       = s1_cmd;
      OP_AUTO: auto_mode_next = s1_cmd;
      OP_TICK: begin
        if (fan) begin
          phase_next = phase + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      temp      <= '0;
      hum       <= '0;
      light     <= '0;
      range_cm  <= '0;
      dist_ok   <= 1'b0;
      lamp      <= 1'b0;
      fan       <= 1'b0;
      auto_mode <= 1'b0;
      fault     <= 1'b0;
      alarm     <= 1'b0;
      phase     <= '0;
    end else begin
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (step) begin
        temp      <= temp_next;
        hum       <= hum_next;
        light     <= light_next;
        range_cm  <= range_cm_next;
        dist_ok   <= dist_ok_next;
        lamp      <= lamp_next;
        fan       <= fan_next;
        auto_mode <= auto_mode_next;
        fault     <= fault_next;
        alarm     <= alarm_next;
        phase     <= phase_next;
      end
    end
  end

  assign status.valid          = out_valid;
  assign status.lamp_on        = lamp;
  assign status.fan_on         = fan;
  assign status.auto_mode      = auto_mode;
  assign status.lamp_fault     = fault;
  assign status.alarm          = alarm;
  assign status.light_pct      = light;
  assign status.range_cm       = range_cm;
  assign status.distance_valid = dist_ok;
  assign status.temp_out       = temp;
  assign status.hum_out        = hum;
  assign status.motor_coils    = fan ? (4'b0001 << phase) : 4'b0000;

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for home_climate_lamp_controller, item and status beats on hclc_if
// directed table then randomized sense/command/tick traffic over several threshold settings
// depends on hclc_pkg, hclc_if and the controller rtl
module tb;
  import hclc_pkg::*;

  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int PIPE_LAT    = 2;
  localparam int QUIET_LIMIT = 500;
  localparam int N_SETTINGS  = 8;
  localparam int SET_ITEMS   = 90;
  localparam int MAX_REPORTS = 200;

  typedef struct packed {
    logic [2:0]  op;
    logic        cmd_value;
    logic        climate_ok;
    logic [7:0]  temp_c;
    logic [7:0]  hum_pct;
    logic [11:0] light_adc;
    logic [11:0] light_after_adc;
    logic        echo_seen;
    logic [15:0] echo_count;
  } item_t;

  typedef struct packed {
    logic        lamp_on;
    logic        fan_on;
    logic        auto_mode;
    logic        lamp_fault;
    logic        alarm;
    logic [6:0]  light_pct;
    logic [10:0] range_cm;
    logic        distance_valid;
    logic [7:0]  temp_out;
    logic [7:0]  hum_out;
    logic [3:0]  motor_coils;
  } status_t;

  typedef struct packed {
    item_t   it;
    logic    typed;
    status_t want;
  } row_t;

  logic clk;
  logic rst;
  logic wr_en;
  cfg_idx_t wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  hclc_item_if   item_ch();
  hclc_status_if status_ch();

  home_climate_lamp_controller uut (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch),
    .status   (status_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // thresholds as the controller should hold them
  logic [7:0]  thr_t_start, thr_t_stop, thr_h_start, thr_h_stop;
  logic [6:0]  thr_dim, thr_glare;
  logic [7:0]  thr_temp_alarm;
  logic [10:0] thr_near;

  // controller state as predicted
  logic [7:0]  ctl_temp, ctl_hum;
  logic [6:0]  ctl_light;
  logic [10:0] ctl_dist;
  logic        ctl_dist_ok, ctl_lamp, ctl_fan, ctl_auto, ctl_fault, ctl_alarm;
  logic [1:0]  ctl_phase;

  status_t pending_status_q[$];
  row_t    dir_rows[$];
  logic [10:0] cfg_vals [8];

  logic    typed_flag;
  status_t typed_want;

  int mismatches = 0;
  int quiet_cycles = 0;
  int sink_cyc = 0;
  int n_items = 0;
  int n_sense = 0;
  int n_beats = 0;
  int n_fault_beats = 0;
  int n_alarm_beats = 0;
  int n_settings = 1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void reset_model();
    thr_t_start    = RST_FAN_TEMP_ON;
    thr_t_stop     = RST_FAN_TEMP_OFF;
    thr_h_start    = RST_FAN_HUM_ON;
    thr_h_stop     = RST_FAN_HUM_OFF;
    thr_dim        = RST_LIGHT_DARK;
    thr_glare      = RST_LIGHT_BRIGHT;
    thr_temp_alarm = RST_TEMP_ALARM_HIGH;
    thr_near       = RST_DIST_ALARM_CM;
    ctl_temp = '0; ctl_hum = '0; ctl_light = '0; ctl_dist = '0; ctl_dist_ok = 1'b0;
    ctl_lamp = 1'b0; ctl_fan = 1'b0; ctl_auto = 1'b0; ctl_fault = 1'b0; ctl_alarm = 1'b0;
    ctl_phase = '0;
  endfunction

  function automatic void apply_reg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_FAN_TEMP_ON:     thr_t_start    = data[7:0];
      REG_FAN_TEMP_OFF:    thr_t_stop     = data[7:0];
      REG_FAN_HUM_ON:      thr_h_start    = data[7:0];
      REG_FAN_HUM_OFF:     thr_h_stop     = data[7:0];
      REG_LIGHT_DARK:      thr_dim        = data[6:0];
      REG_LIGHT_BRIGHT:    thr_glare      = data[6:0];
      REG_TEMP_ALARM_HIGH: thr_temp_alarm = data[7:0];
      REG_DIST_ALARM_CM:   thr_near       = data[10:0];
      default: ;
    endcase
  endfunction

  // low adc is bright: clamp, then scale to 0..100 rounding down
  function automatic int light_percent(logic [11:0] adc);
    int a;
    a = int'(adc);
    if (a < int'(ADC_BRIGHT)) a = int'(ADC_BRIGHT);
    if (a > int'(ADC_DARK)) a = int'(ADC_DARK);
    return ((int'(ADC_DARK) - a) * 100) / (int'(ADC_DARK) - int'(ADC_BRIGHT));
  endfunction

  function automatic status_t next_status(item_t it);
    status_t s;
    int lit, after;
    logic near;
    case (it.op)
      OP_SENSE: begin
        if (it.climate_ok) begin
          ctl_temp = it.temp_c;
          ctl_hum  = it.hum_pct;
        end
        lit = light_percent(it.light_adc);
        ctl_light = 7'(lit);
        if (it.echo_seen) begin
          ctl_dist = 11'(int'(it.echo_count) / ECHO_DIV);
          ctl_dist_ok = 1'b1;
        end else begin
          ctl_dist = '0;
          ctl_dist_ok = 1'b0;
        end
        near = ctl_dist_ok && (ctl_dist < thr_near);
        if (ctl_auto) begin
          after = light_percent(it.light_after_adc);
          if (lit < int'(thr_dim) && !ctl_lamp) begin
            ctl_lamp = 1'b1;
            ctl_fault = (after <= lit + int'(LIGHT_DELTA));
          end else if (lit > int'(thr_glare) && ctl_lamp) begin
            ctl_lamp = 1'b0;
            ctl_fault = (lit <= after + int'(LIGHT_DELTA));
          end
          if ((ctl_temp > thr_t_start || ctl_hum > thr_h_start) && !ctl_fan)
            ctl_fan = 1'b1;
          else if (ctl_temp < thr_t_stop && ctl_hum < thr_h_stop && ctl_fan)
            ctl_fan = 1'b0;
        end
        ctl_alarm = (ctl_temp > thr_temp_alarm) || (ctl_temp < TEMP_ALARM_LOW) ||
                    (ctl_hum > HUM_ALARM_HIGH) || (ctl_hum < HUM_ALARM_LOW) ||
                    ctl_fault || near;
      end
      OP_LAMP: ctl_lamp = it.cmd_value;
      OP_FAN:  ctl_fan  = it.cmd_value;
      OP_AUTO: ctl_auto = it.cmd_value;
      OP_TICK: if (ctl_fan) ctl_phase = ctl_phase + 2'd1;
      default: ;
    endcase
    s.lamp_on        = ctl_lamp;
    s.fan_on         = ctl_fan;
    s.auto_mode      = ctl_auto;
    s.lamp_fault     = ctl_fault;
    s.alarm          = ctl_alarm;
    s.light_pct      = ctl_light;
    s.range_cm       = ctl_dist;
    s.distance_valid = ctl_dist_ok;
    s.temp_out       = ctl_temp;
    s.hum_out        = ctl_hum;
    s.motor_coils    = ctl_fan ? (4'b0001 << ctl_phase) : 4'b0000;
    return s;
  endfunction

  function automatic item_t sense_item(logic ok, logic [7:0] t, logic [7:0] h,
                                       logic [11:0] adc, logic [11:0] after,
                                       logic seen, logic [15:0] cnt);
    item_t it;
    it = '0;
    it.op = OP_SENSE;
    it.climate_ok = ok;
    it.temp_c = t;
    it.hum_pct = h;
    it.light_adc = adc;
    it.light_after_adc = after;
    it.echo_seen = seen;
    it.echo_count = cnt;
    return it;
  endfunction

  function automatic item_t cmd_item(logic [2:0] op, logic val);
    item_t it;
    it = '0;
    it.op = op;
    it.cmd_value = val;
    return it;
  endfunction

  function automatic status_t known(logic lamp, logic fan, logic auto_on, logic fault,
                                    logic alarm, logic [6:0] light, logic [10:0] dist_v,
                                    logic dist_ok, logic [7:0] t, logic [7:0] h,
                                    logic [3:0] coils);
    return '{lamp, fan, auto_on, fault, alarm, light, dist_v, dist_ok, t, h, coils};
  endfunction

  function automatic row_t row(item_t it, logic typed, status_t want);
    return '{it, typed, want};
  endfunction

  function automatic item_t random_item();
    item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.cmd_value  = 1'($urandom_range(0, 1));
    it.climate_ok = ($urandom_range(0, 9) != 0);
    it.temp_c  = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 60))
                                             : 8'($urandom_range(0, 255));
    it.hum_pct = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 100))
                                             : 8'($urandom_range(0, 255));
    it.light_adc = 12'($urandom_range(0, 4095));
    // after-sample near the first one hits the small-change fault path
    if ($urandom_range(0, 1) != 0)
      it.light_after_adc = 12'($urandom_range(0, 4095));
    else
      it.light_after_adc = it.light_adc + 12'($urandom_range(0, 400)) - 12'd200;
    it.echo_seen  = ($urandom_range(0, 4) != 0);
    it.echo_count = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 1500))
                                                : 16'($urandom_range(0, 65535));
    if (pick < 45) begin
      it.op = OP_SENSE;
    end else if (pick < 53) begin
      it.op = OP_LAMP;
    end else if (pick < 61) begin
      it.op = OP_FAN;
    end else if (pick < 71) begin
      it.op = OP_AUTO;
      it.cmd_value = ($urandom_range(0, 3) != 0);
    end else if (pick < 94) begin
      it.op = OP_TICK;
    end else begin
      it.op = 3'($urandom_range(OP_SPARE5, OP_SPARE7));
    end
    return it;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
    end
  endtask

  // scoreboard: predict on each item beat, compare on each status beat
  always @(posedge clk) begin
    status_t due;
    status_t got;
    logic moved;
    if (rst) begin
      reset_model();
      pending_status_q.delete();
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (wr_en) apply_reg_write(wr_index, wr_data);
      if (item_ch.valid && item_ch.ready) begin
        due = next_status('{item_ch.op, item_ch.cmd_value, item_ch.climate_ok,
                            item_ch.temp_c, item_ch.hum_pct, item_ch.light_adc,
                            item_ch.light_after_adc, item_ch.echo_seen,
                            item_ch.echo_count});
        if (typed_flag) due = typed_want;
        pending_status_q.push_back(due);
        n_items++;
        if (item_ch.op == OP_SENSE) n_sense++;
        moved = 1'b1;
      end
      if (status_ch.valid && status_ch.ready) begin
        moved = 1'b1;
        n_beats++;
        got = '{status_ch.lamp_on, status_ch.fan_on, status_ch.auto_mode,
                status_ch.lamp_fault, status_ch.alarm, status_ch.light_pct,
                status_ch.range_cm, status_ch.distance_valid, status_ch.temp_out,
                status_ch.hum_out, status_ch.motor_coils};
        if (pending_status_q.size() == 0) begin
          mismatches++;
          $error("status beat with no item pending");
        end else begin
          due = pending_status_q.pop_front();
          if (due.lamp_fault) n_fault_beats++;
          if (due.alarm) n_alarm_beats++;
          check_field("lamp_on", due.lamp_on, got.lamp_on);
          check_field("fan_on", due.fan_on, got.fan_on);
          check_field("auto_mode", due.auto_mode, got.auto_mode);
          check_field("lamp_fault", due.lamp_fault, got.lamp_fault);
          check_field("alarm", due.alarm, got.alarm);
          check_field("light_pct", due.light_pct, got.light_pct);
          check_field("range_cm", due.range_cm, got.range_cm);
          check_field("distance_valid", due.distance_valid, got.distance_valid);
          check_field("temp_out", due.temp_out, got.temp_out);
          check_field("hum_out", due.hum_out, got.hum_out);
          check_field("motor_coils", due.motor_coils, got.motor_coils);
        end
      end
      if (moved) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("timeout: no beat for %0d cycles, %0d status beats pending",
                   quiet_cycles, pending_status_q.size());
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // status sink stalls: always ready, coin flip, one in four, long stalls
  always @(posedge clk) begin
    sink_cyc <= sink_cyc + 1;
    case (sink_cyc[9:8])
      2'd0: status_ch.ready <= 1'b1;
      2'd1: status_ch.ready <= 1'($urandom_range(0, 1));
      2'd2: status_ch.ready <= (sink_cyc[1:0] == 2'd0);
      default: status_ch.ready <= (sink_cyc[3:0] == 4'hF);
    endcase
  end

  task automatic send_beat(item_t it, logic typed, status_t want);
    logic took;
    item_ch.valid           <= 1'b1;
    item_ch.op              <= it.op;
    item_ch.cmd_value       <= it.cmd_value;
    item_ch.climate_ok      <= it.climate_ok;
    item_ch.temp_c          <= it.temp_c;
    item_ch.hum_pct         <= it.hum_pct;
    item_ch.light_adc       <= it.light_adc;
    item_ch.light_after_adc <= it.light_after_adc;
    item_ch.echo_seen       <= it.echo_seen;
    item_ch.echo_count      <= it.echo_count;
    typed_flag              <= typed;
    typed_want              <= want;
    do begin
      @(negedge clk);
      took = item_ch.ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      item_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic settle_queue();
    item_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_status_q.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_regs();
    for (int i = 0; i < 8; i++) begin
      wr_en    <= 1'b1;
      wr_index <= cfg_idx_t'(i);
      wr_data  <= cfg_vals[i];
      @(posedge clk);
    end
    wr_en <= 1'b0;
  endtask

  task automatic pick_setting(int k);
    case (k)
      0: foreach (cfg_vals[i]) cfg_vals[i] = '0;
      1: foreach (cfg_vals[i]) cfg_vals[i] = '1;
      2: begin
        cfg_vals[REG_FAN_TEMP_ON]     = 11'd255;
        cfg_vals[REG_FAN_TEMP_OFF]    = 11'd255;
        cfg_vals[REG_FAN_HUM_ON]      = 11'd255;
        cfg_vals[REG_FAN_HUM_OFF]     = 11'd255;
        cfg_vals[REG_LIGHT_DARK]      = 11'd100;
        cfg_vals[REG_LIGHT_BRIGHT]    = 11'd100;
        cfg_vals[REG_TEMP_ALARM_HIGH] = 11'd255;
        cfg_vals[REG_DIST_ALARM_CM]   = 11'd1129;
      end
      N_SETTINGS - 1: begin
        cfg_vals[REG_FAN_TEMP_ON]     = 11'(RST_FAN_TEMP_ON);
        cfg_vals[REG_FAN_TEMP_OFF]    = 11'(RST_FAN_TEMP_OFF);
        cfg_vals[REG_FAN_HUM_ON]      = 11'(RST_FAN_HUM_ON);
        cfg_vals[REG_FAN_HUM_OFF]     = 11'(RST_FAN_HUM_OFF);
        cfg_vals[REG_LIGHT_DARK]      = 11'(RST_LIGHT_DARK);
        cfg_vals[REG_LIGHT_BRIGHT]    = 11'(RST_LIGHT_BRIGHT);
        cfg_vals[REG_TEMP_ALARM_HIGH] = 11'(RST_TEMP_ALARM_HIGH);
        cfg_vals[REG_DIST_ALARM_CM]   = 11'(RST_DIST_ALARM_CM);
      end
      default: begin
        // hysteresis bands around the random item ranges
        cfg_vals[REG_FAN_TEMP_ON]     = 11'($urandom_range(15, 45));
        cfg_vals[REG_FAN_TEMP_OFF]    = cfg_vals[REG_FAN_TEMP_ON] - 11'($urandom_range(0, 10));
        cfg_vals[REG_FAN_HUM_ON]      = 11'($urandom_range(40, 90));
        cfg_vals[REG_FAN_HUM_OFF]     = cfg_vals[REG_FAN_HUM_ON] - 11'($urandom_range(0, 20));
        cfg_vals[REG_LIGHT_DARK]      = 11'($urandom_range(5, 50));
        cfg_vals[REG_LIGHT_BRIGHT]    = cfg_vals[REG_LIGHT_DARK] + 11'($urandom_range(0, 50));
        cfg_vals[REG_TEMP_ALARM_HIGH] = 11'($urandom_range(25, 60));
        cfg_vals[REG_DIST_ALARM_CM]   = 11'($urandom_range(0, 40));
      end
    endcase
  endtask

  initial begin
    int burst;
    rst                     <= 1'b1;
    wr_en                   <= 1'b0;
    wr_index                <= REG_FAN_TEMP_ON;
    wr_data                 <= '0;
    typed_flag              <= 1'b0;
    typed_want              <= '0;
    item_ch.valid           <= 1'b0;
    item_ch.op              <= OP_SENSE;
    item_ch.cmd_value       <= 1'b0;
    item_ch.climate_ok      <= 1'b0;
    item_ch.temp_c          <= '0;
    item_ch.hum_pct         <= '0;
    item_ch.light_adc       <= '0;
    item_ch.light_after_adc <= '0;
    item_ch.echo_seen       <= 1'b0;
    item_ch.echo_count      <= '0;

    dir_rows.push_back(row(cmd_item(OP_TICK, 1'b0), 1'b1, '0));
    dir_rows.push_back(row(cmd_item(OP_SPARE5, 1'b0), 1'b1, '0));
    dir_rows.push_back(row(cmd_item(OP_SPARE7, 1'b1), 1'b1, '0));
    dir_rows.push_back(row(sense_item(1'b1, 8'd25, 8'd50, 12'd0, 12'd0, 1'b1, 16'hFFFF), 1'b1,
                           known(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd100, 11'd1129, 1'b1,
                                 8'd25, 8'd50, 4'd0)));
    // failed checksum keeps climate values, no echo clears distance
    dir_rows.push_back(row(sense_item(1'b0, 8'd255, 8'd255, 12'hFFF, 12'hFFF, 1'b0, 16'd1234),
                           1'b1, known(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 11'd0, 1'b0,
                                       8'd25, 8'd50, 4'd0)));
    dir_rows.push_back(row(sense_item(1'b1, 8'd0, 8'd0, 12'd250, 12'd0, 1'b0, 16'd0), 1'b1,
                           known(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 7'd100, 11'd0, 1'b0,
                                 8'd0, 8'd0, 4'd0)));
    dir_rows.push_back(row(sense_item(1'b1, 8'd255, 8'd255, 12'd3600, 12'd0, 1'b1, 16'd57),
                           1'b1, known(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 7'd0, 11'd0, 1'b1,
                                       8'd255, 8'd255, 4'd0)));
    dir_rows.push_back(row(cmd_item(OP_FAN, 1'b1), 1'b0, '0));
    repeat (4) dir_rows.push_back(row(cmd_item(OP_TICK, 1'b0), 1'b0, '0));
    dir_rows.push_back(row(cmd_item(OP_FAN, 1'b0), 1'b0, '0));
    dir_rows.push_back(row(cmd_item(OP_TICK, 1'b1), 1'b0, '0));
    dir_rows.push_back(row(cmd_item(OP_LAMP, 1'b1), 1'b0, '0));
    dir_rows.push_back(row(cmd_item(OP_LAMP, 1'b0), 1'b0, '0));
    dir_rows.push_back(row(cmd_item(OP_AUTO, 1'b1), 1'b0, '0));
    // dark turns lamp on with a good light change, obstacle close
    dir_rows.push_back(row(sense_item(1'b1, 8'd25, 8'd50, 12'd3500, 12'd0, 1'b1, 16'd290),
                           1'b0, '0));
    // bright turns lamp off, light unchanged so fault; warm starts fan
    dir_rows.push_back(row(sense_item(1'b1, 8'd31, 8'd50, 12'd0, 12'd0, 1'b1, 16'd5000),
                           1'b0, '0));
    dir_rows.push_back(row(sense_item(1'b1, 8'd28, 8'd50, 12'd2000, 12'd2000, 1'b0, 16'd0),
                           1'b0, '0));
    dir_rows.push_back(row(sense_item(1'b1, 8'd26, 8'd60, 12'd2000, 12'd2000, 1'b0, 16'd0),
                           1'b0, '0));
    dir_rows.push_back(row(cmd_item(OP_AUTO, 1'b0), 1'b0, '0));
    dir_rows.push_back(row(sense_item(1'b1, 8'd40, 8'd90, 12'd1000, 12'd4000, 1'b1, 16'hFFFF),
                           1'b0, '0));
    dir_rows.push_back(row(cmd_item(OP_SPARE6, 1'b1), 1'b0, '0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
      idle_gap($urandom_range(0, 2));
    end

    for (int k = 0; k < N_SETTINGS; k++) begin
      settle_queue();
      repeat (PIPE_LAT + 2) @(posedge clk);
      pick_setting(k);
      write_regs();
      n_settings++;
      burst = $urandom_range(1, 30);
      for (int n = 0; n < SET_ITEMS; n++) begin
        send_beat(random_item(), 1'b0, '0);
        if (n == SET_ITEMS / 2) begin
          settle_queue();
        end else begin
          burst = burst - 1;
          if (burst == 0) begin
            idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            burst = $urandom_range(1, 30);
          end
        end
      end
    end

    settle_queue();
    repeat (PIPE_LAT + 4) @(posedge clk);
    $display("covered %0d items (%0d sense samples) and %0d status beats over %0d settings",
             n_items, n_sense, n_beats, n_settings);
    $display("lamp fault seen in %0d beats, alarm in %0d beats, %0d mismatches",
             n_fault_beats, n_alarm_beats, mismatches);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/hclc_pkg.sv
rtl/core/hclc_if.sv
rtl/core/hclc_conv.sv
rtl/core/home_climate_lamp_controller.sv
tb/tb.sv
